// File: src/chopper_pi_current_sim_step_assert.svh
// Assertion macros used by the chopper step controller.
`ifndef CHOPPER_PI_CURRENT_SIM_STEP_ASSERT_SVH
`define CHOPPER_PI_CURRENT_SIM_STEP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CHPI_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("chpi assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CHPI_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("chpi assertion failed");

`endif

// File: src/chpi_pkg.sv
// Package: types, constants and microprogram of the chopper step block.
`default_nettype none

package chpi_pkg;

	localparam int WORD_BITS_DEF = 48;
	localparam int FRAC_BITS_DEF = 32;

	// multiplier: 64-bit magnitudes split into two 32-bit digits
	localparam int MUL_BITS = 64;
	localparam int DIG_BITS = 32;
	localparam int ACC_BITS = 2 * MUL_BITS;
	localparam int MUL_PP = (MUL_BITS / DIG_BITS) * (MUL_BITS / DIG_BITS);
	localparam int MCNT_BITS = $clog2(MUL_PP + 1);

	localparam int CFG_IDX_BITS = 4;
	localparam int RF_DEPTH = 16;
	localparam int RF_ADDR_BITS = $clog2(RF_DEPTH);
	localparam int PROG_LEN = 57;
	localparam int PC_BITS = $clog2(PROG_LEN);

	localparam logic [63:0] CFG_RST_SUPPLY = 64'd3435973837;
	localparam logic [63:0] CFG_RST_KP = 64'd429496729600;
	localparam logic [63:0] CFG_RST_KI = 64'd42950;
	localparam logic [63:0] CFG_RST_RFIL = 64'd429496730;
	localparam logic [63:0] CFG_RST_LFIL = 64'd429496730;
	localparam logic [63:0] CFG_RST_CAP = 64'd78090315;
	localparam logic [63:0] CFG_RST_RLOAD = 64'd3006477107;
	localparam logic [63:0] CFG_RST_LLOAD = 64'd1979248;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_SUPPLY = 4'd0,
		CFG_KP = 4'd1,
		CFG_KI = 4'd2,
		CFG_RFIL = 4'd3,
		CFG_LFIL = 4'd4,
		CFG_CAP = 4'd5,
		CFG_RLOAD = 4'd6,
		CFG_LLOAD = 4'd7
	} cfg_idx_t;

	// operand / destination codes: MSB clear selects a scratch register
	typedef enum logic [4:0] {
		R_D0, R_D1, R_D2, R_D3,
		R_P0, R_P1, R_P2, R_P3,
		R_X0, R_X1, R_X2, R_X3,
		R_E, R_T, R_G, R_GU,
		S_Y0, S_Y1, S_Y2, S_Y3,
		S_UZ, S_KP, S_KI, S_RF, S_LF, S_CS, S_RT, S_LL,
		S_SP, S_EMF, S_W4, S_W6
	} opnd_t;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_CLAMP_SYM,
		OP_CLAMP_UNIT,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t op;
		opnd_t dst;
		opnd_t a;
		opnd_t b;
	} instr_t;

	typedef struct packed {
		instr_t instr;
		logic load_in;
		logic rd_en;
		logic alu_wr;
		logic mul_start;
		logic mul_pp;
		logic [1:0] mul_idx;
		logic mul_acc;
		logic mul_wr;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EXEC,
		ST_MUL,
		ST_MWB
	} ctl_state_t;

	function automatic instr_t mk(input op_t op, input opnd_t d, input opnd_t a,
			input opnd_t b);
		instr_t i;
		i.op = op;
		i.dst = d;
		i.a = a;
		i.b = b;
		return i;
	endfunction

	// Microprogram: derivative pass at y, Euler predictor, pass at x,
	// 0.4/0.6 weighted update, result capture.
	function automatic instr_t prog_rom(input logic [PC_BITS-1:0] pc);
		instr_t i;
		unique case (pc)
			// pass at present state
			6'd0: i = mk(OP_SUB, R_E, S_SP, S_Y2);
			6'd1: i = mk(OP_CLAMP_SYM, S_Y3, S_Y3, S_Y3);
			6'd2: i = mk(OP_MUL, R_D3, S_KI, R_E);
			6'd3: i = mk(OP_MUL, R_T, S_KP, R_E);
			6'd4: i = mk(OP_ADD, R_T, R_T, S_Y3);
			6'd5: i = mk(OP_CLAMP_UNIT, R_G, R_T, R_T);
			6'd6: i = mk(OP_MUL, R_GU, R_G, S_Y1);
			6'd7: i = mk(OP_MUL, R_T, S_RF, S_Y0);
			6'd8: i = mk(OP_SUB, R_T, S_UZ, R_T);
			6'd9: i = mk(OP_SUB, R_T, R_T, S_Y1);
			6'd10: i = mk(OP_MUL, R_D0, S_LF, R_T);
			6'd11: i = mk(OP_MUL, R_T, R_G, S_Y2);
			6'd12: i = mk(OP_SUB, R_T, S_Y0, R_T);
			6'd13: i = mk(OP_MUL, R_D1, S_CS, R_T);
			6'd14: i = mk(OP_MUL, R_T, S_RT, S_Y2);
			6'd15: i = mk(OP_SUB, R_T, R_GU, R_T);
			6'd16: i = mk(OP_SUB, R_T, R_T, S_EMF);
			6'd17: i = mk(OP_MUL, R_D2, S_LL, R_T);
			// predictor
			6'd18: i = mk(OP_ADD, R_X0, S_Y0, R_D0);
			6'd19: i = mk(OP_ADD, R_X1, S_Y1, R_D1);
			6'd20: i = mk(OP_ADD, R_X2, S_Y2, R_D2);
			6'd21: i = mk(OP_ADD, R_X3, S_Y3, R_D3);
			// pass at predictor
			6'd22: i = mk(OP_SUB, R_E, S_SP, R_X2);
			6'd23: i = mk(OP_CLAMP_SYM, R_X3, R_X3, R_X3);
			6'd24: i = mk(OP_MUL, R_P3, S_KI, R_E);
			6'd25: i = mk(OP_MUL, R_T, S_KP, R_E);
			6'd26: i = mk(OP_ADD, R_T, R_T, R_X3);
			6'd27: i = mk(OP_CLAMP_UNIT, R_G, R_T, R_T);
			6'd28: i = mk(OP_MUL, R_GU, R_G, R_X1);
			6'd29: i = mk(OP_MUL, R_T, S_RF, R_X0);
			6'd30: i = mk(OP_SUB, R_T, S_UZ, R_T);
			6'd31: i = mk(OP_SUB, R_T, R_T, R_X1);
			6'd32: i = mk(OP_MUL, R_P0, S_LF, R_T);
			6'd33: i = mk(OP_MUL, R_T, R_G, R_X2);
			6'd34: i = mk(OP_SUB, R_T, R_X0, R_T);
			6'd35: i = mk(OP_MUL, R_P1, S_CS, R_T);
			6'd36: i = mk(OP_MUL, R_T, S_RT, R_X2);
			6'd37: i = mk(OP_SUB, R_T, R_GU, R_T);
			6'd38: i = mk(OP_SUB, R_T, R_T, S_EMF);
			6'd39: i = mk(OP_MUL, R_P2, S_LL, R_T);
			// weighted update
			6'd40: i = mk(OP_MUL, R_T, S_W4, R_D0);
			6'd41: i = mk(OP_MUL, R_E, S_W6, R_P0);
			6'd42: i = mk(OP_ADD, R_T, R_T, R_E);
			6'd43: i = mk(OP_ADD, S_Y0, S_Y0, R_T);
			6'd44: i = mk(OP_MUL, R_T, S_W4, R_D1);
			6'd45: i = mk(OP_MUL, R_E, S_W6, R_P1);
			6'd46: i = mk(OP_ADD, R_T, R_T, R_E);
			6'd47: i = mk(OP_ADD, S_Y1, S_Y1, R_T);
			6'd48: i = mk(OP_MUL, R_T, S_W4, R_D2);
			6'd49: i = mk(OP_MUL, R_E, S_W6, R_P2);
			6'd50: i = mk(OP_ADD, R_T, R_T, R_E);
			6'd51: i = mk(OP_ADD, S_Y2, S_Y2, R_T);
			6'd52: i = mk(OP_MUL, R_T, S_W4, R_D3);
			6'd53: i = mk(OP_MUL, R_E, S_W6, R_P3);
			6'd54: i = mk(OP_ADD, R_T, R_T, R_E);
			6'd55: i = mk(OP_ADD, S_Y3, S_Y3, R_T);
			default: i = mk(OP_OUT, R_G, R_G, R_GU);
		endcase
		return i;
	endfunction

endpackage

`default_nettype wire

// File: src/chpi_if.sv
// Channel interfaces: sample items in, result items out, config writes.
`default_nettype none

interface chpi_sample_if import chpi_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) ();
	logic valid;
	logic ready;
	logic signed [WORD_BITS-1:0] current_setpoint;
	logic signed [WORD_BITS-1:0] back_emf;

	modport source(output valid, current_setpoint, back_emf, input ready);
	modport sink(input valid, current_setpoint, back_emf, output ready);
endinterface

interface chpi_result_if import chpi_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) ();
	logic valid;
	logic ready;
	logic [FRAC_BITS:0] duty_ratio;
	logic [WORD_BITS-2:0] chopper_voltage;
	logic signed [WORD_BITS-1:0] out_filter_current;
	logic signed [WORD_BITS-1:0] out_cap_voltage;
	logic signed [WORD_BITS-1:0] out_load_current;

	modport source(output valid, duty_ratio, chopper_voltage, out_filter_current,
		out_cap_voltage, out_load_current, input ready);
	modport sink(input valid, duty_ratio, chopper_voltage, out_filter_current,
		out_cap_voltage, out_load_current, output ready);
endinterface

interface chpi_cfg_if import chpi_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) ();
	logic valid;
	logic ready;
	logic [CFG_IDX_BITS-1:0] index;
	logic [WORD_BITS-2:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/chpi_datapath.sv
// Datapath: config and state registers, scratch memory, saturating ALU, multiplier.
`default_nettype none

module chpi_datapath import chpi_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input cmd_t cmd,
	output stat_t stat,
	input logic [WORD_BITS-1:0] setpoint,
	input logic [WORD_BITS-1:0] emf,
	input logic cfg_we,
	input logic [CFG_IDX_BITS-1:0] cfg_index,
	input logic [WORD_BITS-2:0] cfg_data,
	input logic res_ready,
	output logic res_valid,
	output logic [FRAC_BITS:0] duty_ratio,
	output logic [WORD_BITS-2:0] chopper_voltage,
	output logic [WORD_BITS-1:0] filter_current,
	output logic [WORD_BITS-1:0] cap_voltage,
	output logic [WORD_BITS-1:0] load_current
);

	localparam int W = WORD_BITS;
	localparam int F = FRAC_BITS;
	localparam int CW = W - 1;
	localparam int DW = F + 1;
	localparam logic [MUL_BITS-1:0] MAXV64 = (MUL_BITS'(1) << (W - 1)) - MUL_BITS'(1);
	localparam logic [MUL_BITS-1:0] ONE64 =
		(F >= W - 1) ? MAXV64 : (MUL_BITS'(1) << F);
	localparam logic [MUL_BITS-1:0] W4_64 = ((MUL_BITS'(1) << F) * 2) / 5;
	localparam logic [MUL_BITS-1:0] W6_64 = ((MUL_BITS'(1) << F) * 3) / 5;
	localparam logic [W-1:0] ONE_W = ONE64[W-1:0];
	localparam logic [W-1:0] NEG_ONE_W = W'(0) - ONE_W;
	localparam logic [W-1:0] MINV_W = {1'b1, {(W - 1){1'b0}}};
	localparam logic [W-1:0] MAXV_W = ~MINV_W;

	function automatic logic [MUL_BITS-1:0] sx(input logic [W-1:0] v);
		return MUL_BITS'(signed'(v));
	endfunction

	function automatic logic [W-1:0] sat(input logic [W:0] v);
		if (v[W] != v[W-1]) begin
			return v[W] ? MINV_W : MAXV_W;
		end
		return v[W-1:0];
	endfunction

	// configuration registers
	logic [CW-1:0] uz_q, kp_q, ki_q, rfil_q, lfil_q, cs_q, rt_q, ll_q;
	// integration state
	logic [W-1:0] y0_q, y1_q, y2_q, y3_q;
	// item inputs
	logic [W-1:0] sp_q, emf_q;
	// scratch memory
	logic [W-1:0] rf_mem [RF_DEPTH];
	logic [W-1:0] rd_a_q, rd_b_q;
	// multiplier
	logic mneg_q;
	logic [MUL_BITS-1:0] ma_q, mb_q;
	logic [2*DIG_BITS-1:0] pp_q;
	logic [1:0] pp_sh_q;
	logic [ACC_BITS-1:0] acc_q;
	// result register
	logic out_valid_q;
	logic [DW-1:0] duty_q;
	logic [CW-1:0] vout_q;
	logic [W-1:0] ofi_q, ouc_q, oil_q;

	logic [MUL_BITS-1:0] a64, b64, a_mag, b_mag;
	logic [W-1:0] aw, bw, alu_res, mul_res, wdata;
	logic a_neg, b_neg, wr_en;
	logic [DIG_BITS-1:0] da, db;
	logic [ACC_BITS-1:0] pp_ext, mq, mlim, mmag;
	logic [W+DW-1:0] duty_ext;

	always_comb begin
		unique case (cmd.instr.a)
			S_Y0: a64 = sx(y0_q);
			S_Y1: a64 = sx(y1_q);
			S_Y2: a64 = sx(y2_q);
			S_Y3: a64 = sx(y3_q);
			S_UZ: a64 = MUL_BITS'(uz_q);
			S_KP: a64 = MUL_BITS'(kp_q);
			S_KI: a64 = MUL_BITS'(ki_q);
			S_RF: a64 = MUL_BITS'(rfil_q);
			S_LF: a64 = MUL_BITS'(lfil_q);
			S_CS: a64 = MUL_BITS'(cs_q);
			S_RT: a64 = MUL_BITS'(rt_q);
			S_LL: a64 = MUL_BITS'(ll_q);
			S_SP: a64 = sx(sp_q);
			S_EMF: a64 = sx(emf_q);
			S_W4: a64 = W4_64;
			S_W6: a64 = W6_64;
			default: a64 = sx(rd_a_q);
		endcase
	end

	always_comb begin
		unique case (cmd.instr.b)
			S_Y0: b64 = sx(y0_q);
			S_Y1: b64 = sx(y1_q);
			S_Y2: b64 = sx(y2_q);
			S_Y3: b64 = sx(y3_q);
			S_UZ: b64 = MUL_BITS'(uz_q);
			S_KP: b64 = MUL_BITS'(kp_q);
			S_KI: b64 = MUL_BITS'(ki_q);
			S_RF: b64 = MUL_BITS'(rfil_q);
			S_LF: b64 = MUL_BITS'(lfil_q);
			S_CS: b64 = MUL_BITS'(cs_q);
			S_RT: b64 = MUL_BITS'(rt_q);
			S_LL: b64 = MUL_BITS'(ll_q);
			S_SP: b64 = sx(sp_q);
			S_EMF: b64 = sx(emf_q);
			S_W4: b64 = W4_64;
			S_W6: b64 = W6_64;
			default: b64 = sx(rd_b_q);
		endcase
	end

	assign aw = a64[W-1:0];
	assign bw = b64[W-1:0];

	// saturating add/sub and clamps
	always_comb begin
		unique case (cmd.instr.op)
			OP_ADD: alu_res = sat({aw[W-1], aw} + {bw[W-1], bw});
			OP_SUB: alu_res = sat({aw[W-1], aw} - {bw[W-1], bw});
			OP_CLAMP_SYM: begin
				if ($signed(aw) > $signed(ONE_W)) begin
					alu_res = ONE_W;
				end else if ($signed(aw) < $signed(NEG_ONE_W)) begin
					alu_res = NEG_ONE_W;
				end else begin
					alu_res = aw;
				end
			end
			OP_CLAMP_UNIT: begin
				if (aw[W-1]) begin
					alu_res = '0;
				end else if ($signed(aw) > $signed(ONE_W)) begin
					alu_res = ONE_W;
				end else begin
					alu_res = aw;
				end
			end
			default: alu_res = aw;
		endcase
	end

	// sign/magnitude split for the multiplier
	assign a_neg = a64[MUL_BITS-1];
	assign b_neg = b64[MUL_BITS-1];
	assign a_mag = a_neg ? (MUL_BITS'(0) - a64) : a64;
	assign b_mag = b_neg ? (MUL_BITS'(0) - b64) : b64;

	// digit select: idx[1] picks high digit of a, idx[0] of b
	assign da = cmd.mul_idx[1] ? ma_q[MUL_BITS-1:DIG_BITS] : ma_q[DIG_BITS-1:0];
	assign db = cmd.mul_idx[0] ? mb_q[MUL_BITS-1:DIG_BITS] : mb_q[DIG_BITS-1:0];

	always_comb begin
		unique case (pp_sh_q)
			2'd0: pp_ext = ACC_BITS'(pp_q);
			2'd1: pp_ext = ACC_BITS'(pp_q) << DIG_BITS;
			2'd2: pp_ext = ACC_BITS'(pp_q) << (2 * DIG_BITS);
			default: pp_ext = '0;
		endcase
	end

	// drop fraction, saturate magnitude, apply sign
	assign mq = acc_q >> F;
	assign mlim = mneg_q ? ACC_BITS'(MINV_W) : ACC_BITS'(MAXV_W);
	assign mmag = (mq > mlim) ? mlim : mq;
	assign mul_res = mneg_q ? (W'(0) - mmag[W-1:0]) : mmag[W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			mneg_q <= a_neg ^ b_neg;
			ma_q <= a_mag;
			mb_q <= b_mag;
			// bias toward minus infinity on negative products
			acc_q <= (a_neg ^ b_neg) ? ACC_BITS'((MUL_BITS'(1) << F) - MUL_BITS'(1)) : '0;
		end else if (cmd.mul_acc) begin
			acc_q <= acc_q + pp_ext;
		end
		if (cmd.mul_pp) begin
			pp_q <= da * db;
			pp_sh_q <= 2'(cmd.mul_idx[1]) + 2'(cmd.mul_idx[0]);
		end
	end

	assign wr_en = cmd.alu_wr | cmd.mul_wr;
	assign wdata = cmd.mul_wr ? mul_res : alu_res;

	// scratch memory: one write, two registered reads
	always_ff @(posedge clk) begin
		if (wr_en && !cmd.instr.dst[4]) begin
			rf_mem[cmd.instr.dst[RF_ADDR_BITS-1:0]] <= wdata;
		end
		if (cmd.rd_en) begin
			rd_a_q <= rf_mem[cmd.instr.a[RF_ADDR_BITS-1:0]];
			rd_b_q <= rf_mem[cmd.instr.b[RF_ADDR_BITS-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			sp_q <= setpoint;
			emf_q <= emf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uz_q <= CFG_RST_SUPPLY[CW-1:0];
			kp_q <= CFG_RST_KP[CW-1:0];
			ki_q <= CFG_RST_KI[CW-1:0];
			rfil_q <= CFG_RST_RFIL[CW-1:0];
			lfil_q <= CFG_RST_LFIL[CW-1:0];
			cs_q <= CFG_RST_CAP[CW-1:0];
			rt_q <= CFG_RST_RLOAD[CW-1:0];
			ll_q <= CFG_RST_LLOAD[CW-1:0];
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SUPPLY: uz_q <= cfg_data;
				CFG_KP: kp_q <= cfg_data;
				CFG_KI: ki_q <= cfg_data;
				CFG_RFIL: rfil_q <= cfg_data;
				CFG_LFIL: lfil_q <= cfg_data;
				CFG_CAP: cs_q <= cfg_data;
				CFG_RLOAD: rt_q <= cfg_data;
				CFG_LLOAD: ll_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y0_q <= '0;
			y1_q <= ONE_W;
			y2_q <= '0;
			y3_q <= '0;
		end else if (wr_en) begin
			unique case (cmd.instr.dst)
				S_Y0: y0_q <= wdata;
				S_Y1: y1_q <= wdata;
				S_Y2: y2_q <= wdata;
				S_Y3: y3_q <= wdata;
				default: ;
			endcase
		end
	end

	// duty is nonnegative and at most one: zero-extend, then fit to F+1 bits
	assign duty_ext = (W + DW)'(aw);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			duty_q <= duty_ext[DW-1:0];
			vout_q <= bw[W-1] ? '0 : bw[CW-1:0];
			ofi_q <= y0_q;
			ouc_q <= y1_q;
			oil_q <= y2_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.out_free = !out_valid_q || res_ready;
	assign res_valid = out_valid_q;
	assign duty_ratio = duty_q;
	assign chopper_voltage = vout_q;
	assign filter_current = ofi_q;
	assign cap_voltage = ouc_q;
	assign load_current = oil_q;

endmodule

`default_nettype wire

// File: src/chpi_ctrl.sv
// Controller: microprogram sequencer driving the datapath.
`default_nettype none
`include "chopper_pi_current_sim_step_assert.svh"

module chpi_ctrl import chpi_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output cmd_t cmd,
	input stat_t stat
);

	ctl_state_t state_q, state_d;
	logic [PC_BITS-1:0] pc_q, pc_d;
	logic [MCNT_BITS-1:0] cnt_q, cnt_d;
	instr_t instr;

	assign instr = prog_rom(pc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= '0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			pc_q <= pc_d;
			cnt_q <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pc_d = pc_q;
		cnt_d = cnt_q;
		in_ready = 1'b0;
		cmd = '0;
		cmd.instr = instr;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					pc_d = '0;
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				cmd.rd_en = 1'b1;
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				unique case (instr.op)
					OP_MUL: begin
						cmd.mul_start = 1'b1;
						cnt_d = '0;
						state_d = ST_MUL;
					end
					OP_OUT: begin
						// hold here until the result register frees up
						if (stat.out_free) begin
							cmd.out_load = 1'b1;
							pc_d = '0;
							state_d = ST_IDLE;
						end
					end
					default: begin
						cmd.alu_wr = 1'b1;
						pc_d = pc_q + 1'b1;
						state_d = ST_FETCH;
					end
				endcase
			end
			ST_MUL: begin
				cmd.mul_pp = (cnt_q < MCNT_BITS'(MUL_PP));
				cmd.mul_idx = cnt_q[1:0];
				cmd.mul_acc = (cnt_q != '0);
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == MCNT_BITS'(MUL_PP)) begin
					state_d = ST_MWB;
				end
			end
			ST_MWB: begin
				cmd.mul_wr = 1'b1;
				pc_d = pc_q + 1'b1;
				state_d = ST_FETCH;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`CHPI_ASSERT_NXT(a_accept_starts, state_q == ST_IDLE && in_valid, state_q == ST_FETCH && pc_q == '0)
	`CHPI_ASSERT_IMP(a_mwb_after_drain, state_q == ST_MWB, $past(state_q) == ST_MUL && $past(cnt_q) == MCNT_BITS'(MUL_PP))
	`CHPI_ASSERT_IMP(a_pc_in_program, 1'b1, pc_q < PC_BITS'(PROG_LEN))

endmodule

`default_nettype wire

// File: src/chopper_pi_current_sim_step.sv
// Top level: averaged buck chopper with PI current loop, one RK2 tick per item.
//
// Usage:
//  - sample: one item per integration tick, current_setpoint and back_emf
//    (signed fixed point). Taken only while the sequencer is idle.
//  - result: one item per sample: duty_ratio and chopper_voltage of the
//    predictor pass, plus the updated filter current, cap voltage, load current.
//  - cfg: register writes (index 0..7), always ready, applied the same cycle.
//    Indexes past the list are dropped. Write only while no item is in flight.
// Schedule: the microprogram runs 57 steps on one shared ALU and one
//  multiplier. A multiply goes through fetch, operand setup, four 32x32
//  partial products plus drain and writeback; other steps through fetch
//  and execute. There are 26 multiplies, 30 ALU steps and the output step.
//  A new sample is taken only after the sequencer returns to idle.
// Stall: the result sits in an output register, so a new sample runs while
//  the previous result waits; the sequencer holds at its final step only if
//  that register is still full and not being read.
// Reset: state goes to filter current 0, cap voltage 1.0, load current 0,
//  integrator 0; config registers return to their defaults.
`default_nettype none

module chopper_pi_current_sim_step import chpi_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	chpi_sample_if.sink sample,
	chpi_result_if.source result,
	chpi_cfg_if.sink cfg
);

	cmd_t cmd;
	stat_t stat;

	// config writes always land at once
	assign cfg.ready = 1'b1;

	chpi_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(sample.valid),
		.in_ready(sample.ready),
		.cmd(cmd),
		.stat(stat)
	);

	chpi_datapath #(
		.WORD_BITS(WORD_BITS),
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.setpoint(sample.current_setpoint),
		.emf(sample.back_emf),
		.cfg_we(cfg.valid),
		.cfg_index(cfg.index),
		.cfg_data(cfg.data),
		.res_ready(result.ready),
		.res_valid(result.valid),
		.duty_ratio(result.duty_ratio),
		.chopper_voltage(result.chopper_voltage),
		.filter_current(result.out_filter_current),
		.cap_voltage(result.out_cap_voltage),
		.load_current(result.out_load_current)
	);

endmodule

`default_nettype wire
